[hw/rtl/scre_pkg.sv]
// Shared types, constants and lookup functions for the stepper current register encoder.
// No dependencies; imported by scre_quot and stepper_current_register_encoder.
`timescale 1ns / 1ps

package scre_pkg;

   localparam int unsigned ProdWidth  = 29;   // 12-bit run times 16-bit sqrt2
   localparam int unsigned PeakWidth  = 13;
   localparam int unsigned NumWidth   = 20;   // peak*256 + range/2, peak <= 3000
   localparam int unsigned RecipWidth = 23;
   localparam int unsigned RecipShift = 32;
   localparam int unsigned QuotWidth  = 9;    // quotient never above 256
   localparam int unsigned RmaWidth   = 12;

   localparam logic [15:0] SQRT2_Q15      = 16'd46341;
   localparam logic [31:0] HOLD_RUN_FIXED = 32'h0406_1F00;
   localparam logic [31:0] CHOP_FIXED     = (32'h2 << 15) | (32'h4 << 4) | 32'h3;
   localparam logic [2:0]  QUIET_WORD     = 3'h4;
   localparam logic [3:0]  MRES_DEFAULT   = 4'd6;
   localparam logic [2:0]  RANGE_AUTO     = 3'd0;
   localparam logic [1:0]  RANGE_1A       = 2'd1;
   localparam logic [1:0]  RANGE_2A       = 2'd2;
   localparam logic [1:0]  RANGE_3A       = 2'd3;
   localparam logic [8:0]  HOLD_MAX       = 9'd256;
   localparam logic [8:0]  SCALER_MIN     = 9'd32;

   typedef struct packed {
      logic [11:0] run_current_ma;
      logic [8:0]  hold_fraction;
      logic [2:0]  range_select;
      logic [8:0]  step_divisor;
      logic        stealth_mode;
   } req_type;

   typedef struct packed {
      logic        valid_res;
      logic [1:0]  range_index;
      logic [7:0]  scaler_word;
      logic [31:0] hold_run_word;
      logic [31:0] chopper_word;
      logic [2:0]  global_word;
   } rsp_type;

   // Handed from the range stage to the scaler divide stages.
   typedef struct packed {
      logic                ok;
      logic [1:0]          range_num;
      logic [NumWidth-1:0] num;
      logic [4:0]          hold_idx;
      logic [31:0]         chopper_word;
      logic [2:0]          global_word;
   } frac_type;

   function automatic logic [RmaWidth-1:0] range_ma(input logic [1:0] r);
      logic [RmaWidth-1:0] v;
      case (r)
         RANGE_1A: v = 12'd1000;
         RANGE_2A: v = 12'd2000;
         RANGE_3A: v = 12'd3000;
         default:  v = 12'd1000;
      endcase
      return v;
   endfunction

   // floor(2^32 / range_ma): estimate is low by at most one
   function automatic logic [RecipWidth-1:0] range_recip(input logic [1:0] r);
      logic [RecipWidth-1:0] v;
      case (r)
         RANGE_1A: v = 23'd4294967;
         RANGE_2A: v = 23'd2147483;
         RANGE_3A: v = 23'd1431655;
         default:  v = 23'd4294967;
      endcase
      return v;
   endfunction

   function automatic logic [3:0] mres_of(input logic [8:0] div);
      logic [3:0] v;
      case (div)
         9'd1:    v = 4'd8;
         9'd2:    v = 4'd7;
         9'd4:    v = 4'd6;
         9'd8:    v = 4'd5;
         9'd16:   v = 4'd4;
         9'd32:   v = 4'd3;
         9'd64:   v = 4'd2;
         9'd128:  v = 4'd1;
         9'd256:  v = 4'd0;
         default: v = MRES_DEFAULT;
      endcase
      return v;
   endfunction

endpackage

[hw/rtl/scre_quot.sv]
// Scaler divide stages: reciprocal multiply, then remainder correction and output register.
// Depends on scre_pkg.
`timescale 1ns / 1ps

module scre_quot import scre_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  frac_type in_data,
   output logic     in_ready,
   output logic     out_valid,
   input  logic     out_stall,
   output rsp_type  out_data
);

   logic                 s3_valid_ff, s3_valid_in;
   frac_type             s3_data_ff;
   logic [QuotWidth-1:0] s3_qest_ff, s3_qest_in;
   logic                 s3_ready, s4_ready;
   logic [NumWidth+RecipWidth-1:0] s3_prod;

   logic                 s4_valid_ff, s4_valid_in;
   rsp_type              s4_data_ff, s4_data_in;
   logic [RmaWidth-1:0]  s4_rma;
   logic [NumWidth:0]    s4_prod, s4_rem;
   logic [QuotWidth-1:0] s4_quot;
   logic                 s4_ok;

   assign s4_ready = !s4_valid_ff || !out_stall;
   assign s3_ready = !s3_valid_ff || s4_ready;
   assign in_ready = s3_ready;

   // stage 3: quotient estimate from reciprocal
   assign s3_prod    = {{RecipWidth{1'b0}}, in_data.num} *
                       {{NumWidth{1'b0}}, range_recip(in_data.range_num)};
   assign s3_qest_in = s3_prod[RecipShift +: QuotWidth];
   assign s3_valid_in = s3_ready ? in_valid : s3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready && in_valid) begin
         s3_data_ff <= in_data;
         s3_qest_ff <= s3_qest_in;
      end
   end

   // stage 4: one-step correction, range check, final encoding
   assign s4_rma  = range_ma(s3_data_ff.range_num);
   assign s4_prod = (NumWidth+1)'({{(RmaWidth){1'b0}}, s3_qest_ff} *
                                  {{(QuotWidth){1'b0}}, s4_rma});
   assign s4_rem  = {1'b0, s3_data_ff.num} - s4_prod;
   assign s4_quot = s3_qest_ff + QuotWidth'(s4_rem >= (NumWidth+1)'(s4_rma));
   assign s4_ok   = s3_data_ff.ok && (s4_quot >= SCALER_MIN);

   always_comb begin
      s4_data_in               = '0;
      s4_data_in.chopper_word  = s3_data_ff.chopper_word;
      s4_data_in.global_word   = s3_data_ff.global_word;
      if (s4_ok) begin
         s4_data_in.valid_res     = 1'b1;
         s4_data_in.range_index   = s3_data_ff.range_num - 2'd1;
         s4_data_in.scaler_word   = s4_quot[7:0];   // full scale wraps to zero
         s4_data_in.hold_run_word = HOLD_RUN_FIXED | {27'd0, s3_data_ff.hold_idx};
      end
   end

   assign s4_valid_in = s4_ready ? s3_valid_ff : s4_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s4_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_ready && s3_valid_ff) begin
         s4_data_ff <= s4_data_in;
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_data  = s4_data_ff;

   // estimate must never overshoot, and be low by at most one divisor
   a_quot_low: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && s3_data_ff.ok |-> s4_prod <= {1'b0, s3_data_ff.num})
      else $error("scaler estimate above true quotient");

   a_quot_close: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && s3_data_ff.ok |-> s4_rem < ((NumWidth+1)'(s4_rma) << 1))
      else $error("scaler estimate low by more than one");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_data.valid_res |->
         out_data.range_index == 2'd0 && out_data.scaler_word == 8'd0 &&
         out_data.hold_run_word == 32'd0)
      else $error("rejected request carries nonzero current words");

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_data.valid_res |-> out_data.range_index != 2'd3)
      else $error("range code out of range");

endmodule

[hw/rtl/stepper_current_register_encoder.sv]
// Top level of the stepper current register encoder: input and range stages.
// Depends on scre_pkg and scre_quot.
`timescale 1ns / 1ps

// Usage:
//   req_valid/req_stall/req_data carry one current setup request (req_type).
//   rsp_valid/rsp_stall/rsp_data return one result per request (rsp_type), in order.
//   A transfer happens on a rising edge with valid high and stall low.
// Pipeline: four register stages - sqrt2 multiply, range select and
//   numerator, reciprocal multiply, correction plus output register.
//   rsp_valid is the stage 4 valid register, set as a request moves on from
//   stage 3; throughput is one request per cycle, limited by nothing but
//   the receiver.
// Stalls: each stage holds its contents only while full and blocked, so
//   empty stages keep filling behind a stalled result; req_stall rises once
//   all four stages are full and rsp_stall is high.
// Reset (synchronous, active high) empties the pipeline; there is no other
//   state, and requests are taken in the cycle after reset drops.

module stepper_current_register_encoder import scre_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic                  s1_valid_ff, s1_valid_in, s1_ready;
   logic [ProdWidth-1:0]  s1_prod_ff, s1_prod_in;
   logic                  s1_ok_ff, s1_ok_in;
   logic [2:0]            s1_rsel_ff;
   logic [4:0]            s1_hold_ff, s1_hold_in;
   logic [31:0]           s1_chop_ff, s1_chop_in;
   logic [2:0]            s1_glob_ff, s1_glob_in;
   logic [9:0]            hold_sum;
   logic [6:0]            hold_q;

   logic                  s2_valid_ff, s2_valid_in, s2_ready;
   frac_type              s2_data_ff, s2_data_in;
   logic [PeakWidth-1:0]  peak;
   logic [1:0]            range_num;
   logic                  range_ok;
   logic                  quot_ready;

   assign s2_ready  = !s2_valid_ff || quot_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_stall = !s1_ready;

   // stage 1: peak product, request checks, hold index, fixed words
   assign s1_prod_in = ProdWidth'({16'd0, req_data.run_current_ma} * {12'd0, SQRT2_Q15});
   assign s1_ok_in   = (req_data.run_current_ma != '0) &&
                       (req_data.hold_fraction <= HOLD_MAX) &&
                       !req_data.range_select[2];
   assign hold_sum   = {1'b0, req_data.hold_fraction} + 10'd4;
   assign hold_q     = hold_sum[9:3];

   always_comb begin
      if (hold_q == 7'd0) begin
         s1_hold_in = 5'd0;
      end else if (hold_q > 7'd32) begin
         s1_hold_in = 5'd31;
      end else begin
         s1_hold_in = 5'(hold_q - 7'd1);
      end
   end

   assign s1_chop_in  = ({28'd0, mres_of(req_data.step_divisor)} << 24) | CHOP_FIXED;
   assign s1_glob_in  = req_data.stealth_mode ? QUIET_WORD : 3'd0;
   assign s1_valid_in = s1_ready ? req_valid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req_valid) begin
         s1_prod_ff <= s1_prod_in;
         s1_ok_ff   <= s1_ok_in;
         s1_rsel_ff <= req_data.range_select;
         s1_hold_ff <= s1_hold_in;
         s1_chop_ff <= s1_chop_in;
         s1_glob_ff <= s1_glob_in;
      end
   end

   // stage 2: pick range, check peak fits, form rounded numerator
   // peak = product >> 15
   assign peak = s1_prod_ff[15 +: PeakWidth];

   always_comb begin
      range_ok  = 1'b1;
      range_num = s1_rsel_ff[1:0];
      if (s1_rsel_ff == RANGE_AUTO) begin
         if (peak <= PeakWidth'(1000)) begin
            range_num = RANGE_1A;
         end else if (peak <= PeakWidth'(2000)) begin
            range_num = RANGE_2A;
         end else begin
            range_num = RANGE_3A;
            range_ok  = peak <= PeakWidth'(3000);
         end
      end
   end

   always_comb begin
      s2_data_in.ok           = s1_ok_ff && range_ok &&
                                (peak <= {1'b0, range_ma(range_num)});
      s2_data_in.range_num    = range_num;
      s2_data_in.num          = {peak[11:0], 8'h00} +
                                NumWidth'(range_ma(range_num) >> 1);
      s2_data_in.hold_idx     = s1_hold_ff;
      s2_data_in.chopper_word = s1_chop_ff;
      s2_data_in.global_word  = s1_glob_ff;
   end

   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         s2_data_ff <= s2_data_in;
      end
   end

   scre_quot u_quot (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid_ff),
      .in_data   (s2_data_ff),
      .in_ready  (quot_ready),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_ready |=> s1_valid_ff && $stable(s1_prod_ff))
      else $error("stage 1 request lost under stall");

   a_s2_hold: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !quot_ready |=> s2_valid_ff && $stable(s2_data_ff))
      else $error("stage 2 request lost under stall");

   a_ok_fits: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && s2_data_ff.ok |->
         s2_data_ff.range_num != 2'd0 && s2_data_ff.hold_idx <= 5'd31)
      else $error("accepted request with no range");

endmodule
